// ===== sv/cfru_pkg.sv =====
// Package for the conductor Fresnel reflectance unit: fixed-point widths,
// the pipeline side-band types and the square root and division step functions.
// No dependencies.
`timescale 1ns / 1ps

package cfru_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int COS_W      = FRAC_BITS + 1;
   localparam int IDX_W      = FRAC_BITS + 4;
   localparam int SQR_W      = 24;           // ni^2, no^2, k^2 and their kin
   localparam int MAG_W      = 26;           // |T0|
   localparam int Y_W        = 25;           // 2*no*k
   localparam int RAD_A_W    = 52;           // T0^2 + (2*no*k)^2, padded to even
   localparam int ROOT_A_W   = 26;
   localparam int H_W        = 26;
   localparam int RAD_B_W    = H_W + FRAC_BITS;
   localparam int ROOT_B_W   = RAD_B_W / 2;
   localparam int SQ_REM_W   = 28;
   localparam int DIV_W      = 28;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int SQA_STAGES = RAD_A_W / 2;
   localparam int SQB_STAGES = RAD_B_W / 2;
   localparam int DIV_STAGES = Q_W;

   localparam logic [COS_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct packed {
      logic                fault;
      logic                neg;
      logic [MAG_W-1:0]    mag;
      logic [ROOT_A_W-1:0] a;
      logic [SQR_W-1:0]    c2e;
      logic [COS_W-1:0]    s2s2;
      logic [SQR_W-1:0]    e;
      logic [COS_W-1:0]    c2;
      logic [COS_W-1:0]    s2;
      logic [COS_W-1:0]    c;
      logic [IDX_W-1:0]    ni;
   } side_type;

   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_A_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem1;
      logic [DIV_W-1:0] d1;
      logic [Q_W-1:0]   q1;
      logic [DIV_W-1:0] rem2;
      logic [DIV_W-1:0] d2;
      logic [Q_W-1:0]   q2;
      logic             fault;
   } div_type;

   // One digit of the restoring square root: brings down two radicand bits.
   function automatic sq_type sq_step(input sq_type cur, input logic [1:0] pair);
      logic [SQ_REM_W+1:0] acc;
      logic [SQ_REM_W+1:0] trial;
      sq_type              nxt;
      acc   = {cur.rem, pair};
      trial = (SQ_REM_W + 2)'({cur.root, 2'b01});
      if (acc >= trial) begin
         nxt.rem  = SQ_REM_W'(acc - trial);
         nxt.root = {cur.root[ROOT_A_W-2:0], 1'b1};
      end else begin
         nxt.rem  = acc[SQ_REM_W-1:0];
         nxt.root = {cur.root[ROOT_A_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // One quotient bit of a restoring division; bit 0 of the result is the bit.
   function automatic logic [DIV_W:0] div_step(input logic [DIV_W:0]   acc,
                                                input logic [DIV_W-1:0] d);
      logic [DIV_W:0] res;
      if (acc >= {1'b0, d}) begin
         res = {DIV_W'(acc - {1'b0, d}), 1'b1};
      end else begin
         res = {acc[DIV_W-1:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ===== sv/conductor_fresnel_reflectance_unit.sv =====
// Throughput: one transaction per cycle; busy is never raised and the
// pipeline (two digit-per-stage square roots, two bit-per-stage dividers) never stalls.
// Reset: synchronous, active high; clears every valid bit, drops work in flight.
// Depends on cfru_pkg.
`timescale 1ns / 1ps

module conductor_fresnel_reflectance_unit
   import cfru_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [COS_W-1:0] req_cos_incidence,
   input  logic [IDX_W-1:0] req_index_incident,
   input  logic [IDX_W-1:0] req_index_transmitted,
   input  logic [IDX_W-1:0] req_extinction,
   output logic             rsp_valid,
   output logic [COS_W-1:0] rsp_reflectance,
   output logic             rsp_divide_fault
);

   localparam int LATENCY = 6 + SQA_STAGES + 1 + SQB_STAGES + 4 + DIV_STAGES + 2;

   assign busy = 1'b0;

   // Stage 1: capture, clamp cosine.
   logic             p1_valid_ff;
   logic [COS_W-1:0] p1_c_ff;
   logic [IDX_W-1:0] p1_ni_ff, p1_no_ff, p1_k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= start && !busy;
      end
      p1_c_ff  <= (req_cos_incidence > ONE) ? ONE : req_cos_incidence;
      p1_ni_ff <= req_index_incident;
      p1_no_ff <= req_index_transmitted;
      p1_k_ff  <= req_extinction;
   end

   // Stage 2: squares.
   logic [2*COS_W-1:0] c_sq;
   logic [2*IDX_W-1:0] ni_sq, no_sq, k_sq, nk_prod;
   assign c_sq    = p1_c_ff * p1_c_ff;
   assign ni_sq   = p1_ni_ff * p1_ni_ff;
   assign no_sq   = p1_no_ff * p1_no_ff;
   assign k_sq    = p1_k_ff * p1_k_ff;
   assign nk_prod = p1_no_ff * p1_k_ff;

   logic             p2_valid_ff, p2_fault_ff;
   logic [COS_W-1:0] p2_c2_ff, p2_c_ff;
   logic [SQR_W-1:0] p2_e_ff, p2_n_ff, p2_k2_ff, p2_nk_ff;
   logic [IDX_W-1:0] p2_ni_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
      p2_fault_ff <= (p1_ni_ff == '0);
      p2_c2_ff    <= c_sq[FRAC_BITS+COS_W-1:FRAC_BITS];
      p2_e_ff     <= ni_sq[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p2_n_ff     <= no_sq[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p2_k2_ff    <= k_sq[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p2_nk_ff    <= nk_prod[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p2_c_ff     <= p1_c_ff;
      p2_ni_ff    <= p1_ni_ff;
   end

   // Stage 3: sine squared and the products that scale by E.
   logic [COS_W-1:0]         s2;
   logic [COS_W+SQR_W-1:0]   se_prod, c2e_prod;
   logic [2*COS_W-1:0]       s2s2_prod;
   assign s2        = ONE - p2_c2_ff;
   assign se_prod   = s2 * p2_e_ff;
   assign c2e_prod  = p2_c2_ff * p2_e_ff;
   assign s2s2_prod = s2 * s2;

   logic             p3_valid_ff, p3_fault_ff;
   logic [COS_W-1:0] p3_s2_ff, p3_s2s2_ff, p3_c2_ff, p3_c_ff;
   logic [SQR_W-1:0] p3_se_ff, p3_c2e_ff, p3_n_ff, p3_k2_ff, p3_nk_ff, p3_e_ff;
   logic [IDX_W-1:0] p3_ni_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else begin
         p3_valid_ff <= p2_valid_ff;
      end
      p3_fault_ff <= p2_fault_ff;
      p3_s2_ff    <= s2;
      p3_se_ff    <= se_prod[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p3_c2e_ff   <= c2e_prod[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p3_s2s2_ff  <= s2s2_prod[FRAC_BITS+COS_W-1:FRAC_BITS];
      p3_n_ff     <= p2_n_ff;
      p3_k2_ff    <= p2_k2_ff;
      p3_nk_ff    <= p2_nk_ff;
      p3_e_ff     <= p2_e_ff;
      p3_c2_ff    <= p2_c2_ff;
      p3_c_ff     <= p2_c_ff;
      p3_ni_ff    <= p2_ni_ff;
   end

   // Stage 4: T0 = N - K - s2*E as a sign and a magnitude.
   logic [MAG_W-1:0] t0;
   side_type         p4_side_in;
   assign t0 = MAG_W'(p3_n_ff) - MAG_W'(p3_k2_ff) - MAG_W'(p3_se_ff);

   always_comb begin
      p4_side_in.fault = p3_fault_ff;
      p4_side_in.neg   = t0[MAG_W-1];
      p4_side_in.mag   = t0[MAG_W-1] ? (MAG_W'(0) - t0) : t0;
      p4_side_in.a     = '0;
      p4_side_in.c2e   = p3_c2e_ff;
      p4_side_in.s2s2  = p3_s2s2_ff;
      p4_side_in.e     = p3_e_ff;
      p4_side_in.c2    = p3_c2_ff;
      p4_side_in.s2    = p3_s2_ff;
      p4_side_in.c     = p3_c_ff;
      p4_side_in.ni    = p3_ni_ff;
   end

   logic           p4_valid_ff;
   side_type       p4_side_ff;
   logic [Y_W-1:0] p4_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else begin
         p4_valid_ff <= p3_valid_ff;
      end
      p4_side_ff <= p4_side_in;
      p4_y_ff    <= {p3_nk_ff, 1'b0};
   end

   // Stage 5: the two squares under the first root.
   logic             p5_valid_ff;
   side_type         p5_side_ff;
   logic [2*MAG_W-1:0] p5_xx_ff;
   logic [2*Y_W-1:0]   p5_yy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p5_valid_ff <= 1'b0;
      end else begin
         p5_valid_ff <= p4_valid_ff;
      end
      p5_side_ff <= p4_side_ff;
      p5_xx_ff   <= p4_side_ff.mag * p4_side_ff.mag;
      p5_yy_ff   <= p4_y_ff * p4_y_ff;
   end

   // Stage 6: radicand of A.
   logic               p6_valid_ff;
   side_type           p6_side_ff;
   logic [RAD_A_W-1:0] p6_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p6_valid_ff <= 1'b0;
      end else begin
         p6_valid_ff <= p5_valid_ff;
      end
      p6_side_ff <= p5_side_ff;
      p6_rad_ff  <= RAD_A_W'(p5_xx_ff) + RAD_A_W'(p5_yy_ff);
   end

   // Square root A, one result bit per stage.
   logic               sqa_valid_ff [SQA_STAGES];
   side_type           sqa_side_ff  [SQA_STAGES];
   sq_type             sqa_acc_ff   [SQA_STAGES];
   logic [RAD_A_W-1:0] sqa_rad_ff   [SQA_STAGES];

   for (genvar i = 0; i < SQA_STAGES; i++) begin : gen_sqa
      logic               valid_src;
      side_type           side_src;
      sq_type             acc_src;
      logic [RAD_A_W-1:0] rad_src;
      if (i == 0) begin : gen_first
         assign valid_src = p6_valid_ff;
         assign side_src  = p6_side_ff;
         assign acc_src   = '0;
         assign rad_src   = p6_rad_ff;
      end else begin : gen_next
         assign valid_src = sqa_valid_ff[i-1];
         assign side_src  = sqa_side_ff[i-1];
         assign acc_src   = sqa_acc_ff[i-1];
         assign rad_src   = sqa_rad_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqa_valid_ff[i] <= 1'b0;
         end else begin
            sqa_valid_ff[i] <= valid_src;
         end
         sqa_side_ff[i] <= side_src;
         sqa_acc_ff[i]  <= sq_step(acc_src, rad_src[RAD_A_W-1:RAD_A_W-2]);
         sqa_rad_ff[i]  <= {rad_src[RAD_A_W-3:0], 2'b00};
      end
   end

   // Stage 7: (A + T0) / 2, floored at zero when T0 is negative.
   side_type           p7_side_in;
   logic [H_W:0]       h_sum;
   logic [ROOT_A_W-1:0] a_root;
   assign a_root = sqa_acc_ff[SQA_STAGES-1].root;

   always_comb begin
      p7_side_in   = sqa_side_ff[SQA_STAGES-1];
      p7_side_in.a = a_root;
      if (p7_side_in.neg) begin
         h_sum = (a_root > p7_side_in.mag) ? (H_W + 1)'(a_root - p7_side_in.mag) : '0;
      end else begin
         h_sum = (H_W + 1)'(a_root) + (H_W + 1)'(p7_side_in.mag);
      end
   end

   logic               p7_valid_ff;
   side_type           p7_side_ff;
   logic [RAD_B_W-1:0] p7_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p7_valid_ff <= 1'b0;
      end else begin
         p7_valid_ff <= sqa_valid_ff[SQA_STAGES-1];
      end
      p7_side_ff <= p7_side_in;
      p7_rad_ff  <= {h_sum[H_W:1], {FRAC_BITS{1'b0}}};
   end

   // Square root Ae.
   logic               sqb_valid_ff [SQB_STAGES];
   side_type           sqb_side_ff  [SQB_STAGES];
   sq_type             sqb_acc_ff   [SQB_STAGES];
   logic [RAD_B_W-1:0] sqb_rad_ff   [SQB_STAGES];

   for (genvar i = 0; i < SQB_STAGES; i++) begin : gen_sqb
      logic               valid_src;
      side_type           side_src;
      sq_type             acc_src;
      logic [RAD_B_W-1:0] rad_src;
      if (i == 0) begin : gen_first
         assign valid_src = p7_valid_ff;
         assign side_src  = p7_side_ff;
         assign acc_src   = '0;
         assign rad_src   = p7_rad_ff;
      end else begin : gen_next
         assign valid_src = sqb_valid_ff[i-1];
         assign side_src  = sqb_side_ff[i-1];
         assign acc_src   = sqb_acc_ff[i-1];
         assign rad_src   = sqb_rad_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqb_valid_ff[i] <= 1'b0;
         end else begin
            sqb_valid_ff[i] <= valid_src;
         end
         sqb_side_ff[i] <= side_src;
         sqb_acc_ff[i]  <= sq_step(acc_src, rad_src[RAD_B_W-1:RAD_B_W-2]);
         sqb_rad_ff[i]  <= {rad_src[RAD_B_W-3:0], 2'b00};
      end
   end

   // Stage 8: first products with Ae and A.
   side_type              sb;
   logic [ROOT_B_W-1:0]   ae;
   logic [COS_W+ROOT_B_W-1:0] cae_prod;
   logic [COS_W+ROOT_A_W-1:0] ca_prod;
   logic [COS_W+SQR_W-1:0]    sse_prod;
   assign sb       = sqb_side_ff[SQB_STAGES-1];
   assign ae       = sqb_acc_ff[SQB_STAGES-1].root[ROOT_B_W-1:0];
   assign cae_prod = sb.c * ae;
   assign ca_prod  = sb.c2 * sb.a;
   assign sse_prod = sb.s2s2 * sb.e;

   logic                p8_valid_ff, p8_fault_ff;
   logic [ROOT_B_W-1:0] p8_cae_ff;
   logic [ROOT_A_W:0]   p8_t1_ff;
   logic [ROOT_A_W-1:0] p8_ca_ff;
   logic [SQR_W-1:0]    p8_sse_ff;
   logic [IDX_W-1:0]    p8_ni_ff;
   logic [COS_W-1:0]    p8_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p8_valid_ff <= 1'b0;
      end else begin
         p8_valid_ff <= sqb_valid_ff[SQB_STAGES-1];
      end
      p8_fault_ff <= sb.fault;
      p8_cae_ff   <= cae_prod[FRAC_BITS+ROOT_B_W-1:FRAC_BITS];
      p8_t1_ff    <= (ROOT_A_W + 1)'(sb.a) + (ROOT_A_W + 1)'(sb.c2e);
      p8_ca_ff    <= ca_prod[FRAC_BITS+ROOT_A_W-1:FRAC_BITS];
      p8_sse_ff   <= sse_prod[FRAC_BITS+SQR_W-1:FRAC_BITS];
      p8_ni_ff    <= sb.ni;
      p8_s2_ff    <= sb.s2;
   end

   // Stage 9: t2 and t3.
   logic [ROOT_B_W+IDX_W-1:0] t2_prod;
   assign t2_prod = p8_cae_ff * p8_ni_ff;

   logic                p9_valid_ff, p9_fault_ff;
   logic [ROOT_A_W-1:0] p9_t2_ff;
   logic [ROOT_A_W:0]   p9_t1_ff, p9_t3_ff;
   logic [COS_W-1:0]    p9_s2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p9_valid_ff <= 1'b0;
      end else begin
         p9_valid_ff <= p8_valid_ff;
      end
      p9_fault_ff <= p8_fault_ff;
      p9_t2_ff    <= {t2_prod[FRAC_BITS+ROOT_A_W-2:FRAC_BITS], 1'b0};
      p9_t3_ff    <= (ROOT_A_W + 1)'(p8_ca_ff) + (ROOT_A_W + 1)'(p8_sse_ff);
      p9_t1_ff    <= p8_t1_ff;
      p9_s2_ff    <= p8_s2_ff;
   end

   // Stage 10: t4 and the Rs operands.
   logic [ROOT_A_W+COS_W-1:0] t4_prod;
   assign t4_prod = p9_t2_ff * p9_s2_ff;

   logic                p10_valid_ff, p10_fault_ff;
   logic [ROOT_A_W:0]   p10_t3_ff;
   logic [ROOT_A_W-1:0] p10_t4_ff;
   logic [DIV_W-1:0]    p10_d1_ff, p10_diff1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p10_valid_ff <= 1'b0;
      end else begin
         p10_valid_ff <= p9_valid_ff;
      end
      p10_fault_ff <= p9_fault_ff;
      p10_t3_ff    <= p9_t3_ff;
      p10_t4_ff    <= t4_prod[FRAC_BITS+ROOT_A_W-1:FRAC_BITS];
      p10_d1_ff    <= DIV_W'(p9_t1_ff) + DIV_W'(p9_t2_ff);
      p10_diff1_ff <= (p9_t1_ff > (ROOT_A_W + 1)'(p9_t2_ff))
                      ? DIV_W'(p9_t1_ff - (ROOT_A_W + 1)'(p9_t2_ff)) : '0;
   end

   // Stage 11: Rp ratio operands and the divide-by-zero check.
   logic [DIV_W-1:0] d2;
   div_type          p11_in;
   assign d2 = DIV_W'(p10_t3_ff) + DIV_W'(p10_t4_ff);

   always_comb begin
      p11_in.rem1  = p10_diff1_ff;
      p11_in.d1    = p10_d1_ff;
      p11_in.q1    = '0;
      p11_in.rem2  = (p10_t3_ff > (ROOT_A_W + 1)'(p10_t4_ff))
                     ? DIV_W'(p10_t3_ff - (ROOT_A_W + 1)'(p10_t4_ff)) : '0;
      p11_in.d2    = d2;
      p11_in.q2    = '0;
      p11_in.fault = p10_fault_ff || (p10_d1_ff == '0) || (d2 == '0);
   end

   logic    p11_valid_ff;
   div_type p11_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p11_valid_ff <= 1'b0;
      end else begin
         p11_valid_ff <= p10_valid_ff;
      end
      p11_ff <= p11_in;
   end

   // Two dividers side by side; the first step yields the integer bit, the
   // numerators never exceed their divisors, so quotients stay within one.
   logic    dv_valid_ff [DIV_STAGES];
   div_type dv_ff       [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : gen_div
      logic           valid_src;
      div_type        src;
      div_type        nxt;
      logic [DIV_W:0] acc1, acc2, res1, res2;
      if (j == 0) begin : gen_first
         assign valid_src = p11_valid_ff;
         assign src       = p11_ff;
         assign acc1      = {1'b0, src.rem1};
         assign acc2      = {1'b0, src.rem2};
      end else begin : gen_next
         assign valid_src = dv_valid_ff[j-1];
         assign src       = dv_ff[j-1];
         assign acc1      = {src.rem1, 1'b0};
         assign acc2      = {src.rem2, 1'b0};
      end
      assign res1 = div_step(acc1, src.d1);
      assign res2 = div_step(acc2, src.d2);
      always_comb begin
         nxt      = src;
         nxt.rem1 = res1[DIV_W:1];
         nxt.q1   = {src.q1[Q_W-2:0], res1[0]};
         nxt.rem2 = res2[DIV_W:1];
         nxt.q2   = {src.q2[Q_W-2:0], res2[0]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else begin
            dv_valid_ff[j] <= valid_src;
         end
         dv_ff[j] <= nxt;
      end
   end

   // Stage 12: Rp = Rs * ratio.
   div_type          dl;
   logic [2*Q_W-1:0] rp_prod;
   assign dl      = dv_ff[DIV_STAGES-1];
   assign rp_prod = dl.q1 * dl.q2;

   logic             p12_valid_ff, p12_fault_ff;
   logic [Q_W-1:0]   p12_rs_ff, p12_rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p12_valid_ff <= 1'b0;
      end else begin
         p12_valid_ff <= dv_valid_ff[DIV_STAGES-1];
      end
      p12_fault_ff <= dl.fault;
      p12_rs_ff    <= dl.q1;
      p12_rp_ff    <= rp_prod[FRAC_BITS+Q_W-1:FRAC_BITS];
   end

   // Stage 13: mean of the two terms, result register.
   logic [Q_W:0]     r_sum;
   logic [COS_W-1:0] r_mean;
   assign r_sum  = (Q_W + 1)'(p12_rs_ff) + (Q_W + 1)'(p12_rp_ff);
   assign r_mean = (r_sum[Q_W:1] > ONE) ? ONE : r_sum[Q_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= p12_valid_ff;
      end
      rsp_reflectance  <= p12_fault_ff ? ONE : r_mean;
      rsp_divide_fault <= p12_fault_ff;
   end

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##LATENCY rsp_valid)
      else $error("transaction result did not appear at the fixed latency");

   a_zero_index: assert property (@(posedge clock) disable iff (reset)
      (start && (req_index_incident == '0)) |-> ##LATENCY (rsp_valid && rsp_divide_fault))
      else $error("zero incident index did not raise the fault");

   a_fault_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_fault) |-> (rsp_reflectance == ONE))
      else $error("faulted result is not forced to one");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reflectance <= ONE))
      else $error("reflectance above one");
`endif

endmodule

// ===== test/testbench.sv =====
// Testbench for conductor_fresnel_reflectance_unit: drives ray hits, predicts
// the unpolarized conductor reflectance in fixed point and checks every result.
// Depends on cfru_pkg and the unit itself.
`timescale 1ns / 1ps

module testbench
   import cfru_pkg::*;
();

   typedef struct {
      logic [COS_W-1:0] cos_v;
      logic [IDX_W-1:0] ni;
      logic [IDX_W-1:0] no;
      logic [IDX_W-1:0] kx;
   } hit_type;

   typedef struct {
      logic [COS_W-1:0] refl;
      logic             fault;
   } refl_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 120;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [COS_W-1:0] req_cos_incidence = '0;
   logic [IDX_W-1:0] req_index_incident = '0;
   logic [IDX_W-1:0] req_index_transmitted = '0;
   logic [IDX_W-1:0] req_extinction = '0;
   logic             rsp_valid;
   logic [COS_W-1:0] rsp_reflectance;
   logic             rsp_divide_fault;

   hit_type  pending_hits[$];
   refl_type expected_refl[$];
   int       mismatch_count = 0;
   int       hits_sent = 0;
   int       results_seen = 0;
   int       faults_seen = 0;
   int       idle_count = 0;
   int       cycle_count = 0;
   logic     accepted_last = 1'b0;

   conductor_fresnel_reflectance_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cos_incidence     (req_cos_incidence),
      .req_index_incident    (req_index_incident),
      .req_index_transmitted (req_index_transmitted),
      .req_extinction        (req_extinction),
      .rsp_valid             (rsp_valid),
      .rsp_reflectance       (rsp_reflectance),
      .rsp_divide_fault      (rsp_divide_fault)
   );

   always #2 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
      return (a * b) >> FRAC_BITS;
   endfunction

   function automatic refl_type predict_reflectance(hit_type h);
      refl_type        res;
      longint unsigned one, c, ni, no, kx, c2, s2, e, n, k2, se, mag, y, a, hh, ae;
      longint unsigned t1, t2, d1, rs, t3, t4, d2, q, rp, refl;
      longint          t0;
      int              sh;
      one = 64'd1 << FRAC_BITS;
      c = h.cos_v;
      ni = h.ni;
      no = h.no;
      kx = h.kx;
      res.refl = ONE;
      res.fault = 1'b1;
      if (c > one) c = one;
      if (ni != 0) begin
         c2 = fmul(c, c);
         s2 = one - c2;
         e = fmul(ni, ni);
         n = fmul(no, no);
         k2 = fmul(kx, kx);
         se = fmul(s2, e);
         t0 = longint'(n) - longint'(k2) - longint'(se);
         mag = (t0 < 0) ? longint'(-t0) : t0;
         y = 2 * fmul(no, kx);
         // Scale both legs down together so the squares stay in 64 bits.
         sh = 0;
         while (((mag | y) >> 31) != 0) begin
            mag = mag >> 1;
            y = y >> 1;
            sh++;
         end
         a = int_sqrt(mag * mag + y * y) << sh;
         mag = (t0 < 0) ? longint'(-t0) : t0;
         if (t0 < 0) hh = (a > mag) ? a - mag : 0;
         else hh = a + mag;
         hh = hh >> 1;
         ae = int_sqrt(hh << FRAC_BITS);
         t1 = a + fmul(c2, e);
         t2 = 2 * fmul(fmul(c, ae), ni);
         d1 = t1 + t2;
         if (d1 != 0) begin
            rs = (((t1 > t2) ? t1 - t2 : 0) << FRAC_BITS) / d1;
            if (rs > one) rs = one;
            t3 = fmul(c2, a) + fmul(fmul(s2, s2), e);
            t4 = fmul(t2, s2);
            d2 = t3 + t4;
            if (d2 != 0) begin
               q = (((t3 > t4) ? t3 - t4 : 0) << FRAC_BITS) / d2;
               if (q > one) q = one;
               rp = fmul(rs, q);
               refl = (rs + rp) >> 1;
               if (refl > one) refl = one;
               res.refl = refl[COS_W-1:0];
               res.fault = 1'b0;
            end
         end
      end
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return IDX_W'($urandom_range(1, 16));
         3, 4: return IDX_W'($urandom);
         default: return IDX_W'($urandom_range(32'h08000, 32'h60000));
      endcase
   endfunction

   task automatic queue_hit(input logic [COS_W-1:0] cv, input logic [IDX_W-1:0] ni,
                            input logic [IDX_W-1:0] no, input logic [IDX_W-1:0] kx);
      hit_type h;
      h.cos_v = cv;
      h.ni = ni;
      h.no = no;
      h.kx = kx;
      pending_hits.push_back(h);
   endtask

   initial begin
      logic [COS_W-1:0] cv;
      // Directed hits: field extremes, saturated cosine, zero incident index,
      // zero divisors, grazing and normal incidence, dielectric-like k = 0.
      queue_hit('0, '0, '0, '0);
      queue_hit(ONE, '1, '1, '1);
      queue_hit('1, 20'h10000, 20'h20000, 20'h30000);
      queue_hit(COS_W'(ONE + 1), 20'h10000, 20'h18000, 20'h0);
      queue_hit(ONE, '0, 20'h20000, 20'h30000);
      queue_hit('0, 20'h10000, '0, '0);
      queue_hit('0, 20'h1, '0, '0);
      queue_hit(ONE, 20'h1, 20'h1, 20'h1);
      queue_hit(ONE, 20'h10000, '0, '0);
      queue_hit(ONE, 20'h10000, 20'h10000, '0);
      queue_hit(17'h0B505, 20'h10000, 20'h0C000, 20'h0);
      queue_hit(17'h08000, 20'h10000, 20'h02800, 20'h3C000);
      queue_hit(17'h00100, 20'h15000, 20'h2A000, 20'h48000);
      queue_hit(ONE, 20'h10000, '1, '0);
      queue_hit(ONE, 20'h10000, '0, '1);
      queue_hit('0, '1, '1, '1);
      queue_hit('0, '1, '0, '0);
      queue_hit(17'h0FFFF, 20'h80000, 20'h40000, 20'h20000);
      queue_hit(17'h05555, 20'hAAAAA, 20'h55555, 20'hAAAAA);
      queue_hit(17'h1AAAA, 20'h55555, 20'hAAAAA, 20'h55555);
      for (int i = 0; i < 1650; i++) begin
         case ($urandom_range(0, 7))
            0: cv = COS_W'($urandom);
            1: cv = ($urandom_range(0, 1) == 1) ? ONE : '0;
            default: cv = COS_W'($urandom_range(0, 32'h10000));
         endcase
         queue_hit(cv, rand_index(), rand_index(), rand_index());
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Driver: during a window of cycle_count it offers a transaction every cycle while hits remain.
   always @(negedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (pending_hits.size() != 0 && (!start || accepted_last)
             && (($urandom_range(0, 99) >= 34) || (cycle_count > 1000 && cycle_count < 1800)))
         begin
            req_cos_incidence     <= pending_hits[0].cos_v;
            req_index_incident    <= pending_hits[0].ni;
            req_index_transmitted <= pending_hits[0].no;
            req_extinction        <= pending_hits[0].kx;
            start                 <= 1'b1;
         end else if (!start || accepted_last) begin
            start <= 1'b0;
            req_cos_incidence <= COS_W'($urandom);
         end
      end
   end

   // Monitor: records accepted hits and checks results at the rising edge.
   always @(posedge clock) begin
      refl_type got;
      refl_type want;
      hit_type  h;
      bit       took;
      bit       active;
      took = 1'b0;
      active = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            h = pending_hits.pop_front();
            expected_refl.push_back(predict_reflectance(h));
            hits_sent++;
            took = 1'b1;
            active = 1'b1;
         end
         if (rsp_valid) begin
            active = 1'b1;
            got.refl = rsp_reflectance;
            got.fault = rsp_divide_fault;
            results_seen++;
            if (got.fault) faults_seen++;
            if (expected_refl.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result: refl=%0h fault=%0b", got.refl, got.fault);
            end else begin
               want = expected_refl.pop_front();
               if (got.refl !== want.refl || got.fault !== want.fault) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch %0d: expected refl=%0h fault=%0b, got refl=%0h fault=%0b",
                              results_seen, want.refl, want.fault, got.refl, got.fault);
               end
            end
         end
         idle_count <= active ? 0 : idle_count + 1;
      end
      accepted_last <= took;
   end

   initial begin
      wait (!reset);
      while (!(pending_hits.size() == 0 && expected_refl.size() == 0)
             && idle_count < WATCHDOG_LIMIT)
         @(posedge clock);
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
      end else begin
         repeat (DRAIN_CYCLES) @(posedge clock);
         $display("covered %0d ray hits, %0d results, %0d with divide fault",
                  hits_sent, results_seen, faults_seen);
         if (mismatch_count == 0 && expected_refl.size() == 0) begin
            $display("testbench: done, clean");
         end else begin
            $display("%0d mismatches", mismatch_count);
            $display("testbench: done, errors");
         end
      end
      $finish;
   end

endmodule

// ===== conductor_fresnel_reflectance_unit.f =====
sv/cfru_pkg.sv
sv/conductor_fresnel_reflectance_unit.sv
test/testbench.sv
